[design/assert_macros.svh]
// assertion helpers for the bound property checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define CUP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// implication after a fixed number of cycles
`define CUP_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("delayed check failed");

`endif

[design/cup_pkg.sv]
`default_nettype none

package cup_pkg;

	localparam int CoordW  = 20;
	localparam int VecW    = 48;
	localparam int RadW    = 19;
	localparam int ArcW    = 22;
	localparam int CfgIdxW = 2;

	localparam int SqN      = 31;
	localparam int DivN     = 20;
	localparam int TurnBits = 24;
	localparam int Latency  = 7 + SqN + DivN + 2;

	localparam logic [30:0] TwoPiQ28 = 31'd1686629713;
	localparam int RClamp = 4194303;
	localparam logic [ArcW:0] ArcMax = 23'd4194303;

	localparam logic [VecW-1:0] AxisDirRst = 48'h0000_4000_0000;
	localparam logic [VecW-1:0] RefDirRst  = 48'h4000_0000_0000;
	localparam logic [RadW-1:0] RadRst     = 19'd40960;

	localparam logic [21:0] AtanTurn [24] = '{
		22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
		22'd41718, 22'd20860, 22'd10430, 22'd5215, 22'd2608, 22'd1304,
		22'd652, 22'd326, 22'd163, 22'd81, 22'd41, 22'd20,
		22'd10, 22'd5, 22'd3, 22'd1, 22'd1, 22'd0
	};

	typedef enum logic [CfgIdxW-1:0] {
		REG_AXIS_POINT = 2'd0,
		REG_AXIS_DIR   = 2'd1,
		REG_REF_DIR    = 2'd2,
		REG_CYL_RADIUS = 2'd3
	} cfg_reg_t;

	function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [28:0] x);
		logic signed [CoordW-1:0] res;
		if (x > 29'sd524287) begin
			res = 20'sd524287;
		end else if (x < -29'sd524288) begin
			res = -20'sd524288;
		end else begin
			res = x[CoordW-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[design/cylinder_unwrap_projector.sv]
// a result shows on done for each item that a start edge took
// throughput: one item per cycle, busy never rises, results cannot be held off
// the path to done runs through the 31-step square root and the 20-step divider in series
// reset clears all valid bits and loads the default cylinder registers
`default_nettype none

module cylinder_unwrap_projector #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire  logic                                 clk,
	input  wire  logic                                 arst_n,
	input  wire  logic                                 start,
	output logic                                       busy,
	input  wire  logic signed [cup_pkg::CoordW-1:0]    point_x,
	input  wire  logic signed [cup_pkg::CoordW-1:0]    point_y,
	input  wire  logic signed [cup_pkg::CoordW-1:0]    point_z,
	input  wire  logic                                 cfg_we,
	input  wire  logic        [cup_pkg::CfgIdxW-1:0]   cfg_idx,
	input  wire  logic        [cup_pkg::VecW-1:0]      cfg_wdata,
	output logic                                       done,
	output logic signed       [cup_pkg::CoordW-1:0]    surf_x,
	output logic signed       [cup_pkg::CoordW-1:0]    surf_y,
	output logic signed       [cup_pkg::CoordW-1:0]    surf_z,
	output logic              [cup_pkg::ArcW-1:0]      arc_pos,
	output logic signed       [cup_pkg::CoordW-1:0]    height,
	output logic                                       on_axis
);
	import cup_pkg::*;

	localparam int ArcDly = SqN + 1 + DivN - CORDIC_STEPS - 3;

	typedef struct packed {
		logic                   hit;
		logic signed [24:0]     hq;
		logic [2:0][27:0]       tc;
		logic [2:0]             neg;
	} tail_t;

	// configuration
	logic [VecW-1:0] axis_point_q, axis_dir_q, ref_dir_q;
	logic [RadW-1:0] cyl_radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_point_q <= '0;
			axis_dir_q   <= AxisDirRst;
			ref_dir_q    <= RefDirRst;
			cyl_radius_q <= RadRst;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_AXIS_POINT: axis_point_q <= cfg_wdata;
				REG_AXIS_DIR:   axis_dir_q   <= cfg_wdata;
				REG_REF_DIR:    ref_dir_q    <= cfg_wdata;
				REG_CYL_RADIUS: cyl_radius_q <= cfg_wdata[RadW-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic signed [15:0] c_c [3];
	logic signed [15:0] a_c [3];
	logic signed [15:0] s_c [3];
	logic signed [19:0] c16 [3];
	logic signed [CoordW-1:0] pt [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_c[i] = axis_point_q[16*i +: 16];
			a_c[i] = axis_dir_q[16*i +: 16];
			s_c[i] = ref_dir_q[16*i +: 16];
			c16[i] = {c_c[i], 4'b0000};
		end
	end

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// derived cylinder terms: w = ref x axis and the circumference
	logic signed [32:0] wd [3];
	logic signed [32:0] wr [3];
	logic signed [18:0] w_q [3];
	logic [49:0] circ_p;
	logic [35:0] circ_q;

	always_comb begin
		wd[0] = s_c[1] * a_c[2] - s_c[2] * a_c[1];
		wd[1] = s_c[2] * a_c[0] - s_c[0] * a_c[2];
		wd[2] = s_c[0] * a_c[1] - s_c[1] * a_c[0];
		for (int i = 0; i < 3; i++) begin
			wr[i] = wd[i] + 33'sd8192;
		end
		circ_p = cyl_radius_q * TwoPiQ28 + 50'd8192;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			w_q[i] <= wr[i][32:14];
		end
		circ_q <= circ_p[49:14];
	end

	// front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [20:0] d_s1 [3];
	logic signed [20:0] d_s2 [3];
	logic signed [20:0] d_s3 [3];
	logic signed [20:0] d_s4 [3];
	logic signed [36:0] hp_s2 [3];
	logic signed [38:0] hf, hfr;
	logic signed [24:0] hq_s3, hq_s4, hq_s5, hq_s6;
	logic signed [40:0] kp_s4 [3];
	logic signed [40:0] kr [3];
	logic signed [26:0] k_c [3];
	logic signed [27:0] df [3];
	logic signed [22:0] r_c [3];
	logic signed [22:0] r_s5 [3];
	logic signed [27:0] tc_s5 [3];
	logic signed [27:0] tc_s6 [3];
	logic signed [38:0] us_s6 [3];
	logic signed [41:0] vw_s6 [3];
	logic signed [45:0] rr_s6 [3];
	logic signed [42:0] nr_s6 [3];
	logic hit_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		hf  = hp_s2[0] + hp_s2[1] + hp_s2[2];
		hfr = hf + 39'sd8192;
		for (int i = 0; i < 3; i++) begin
			kr[i]  = kp_s4[i] + 41'sd8192;
			k_c[i] = kr[i][40:14];
			df[i]  = d_s4[i] - k_c[i];
			if (df[i] > 28'(RClamp)) begin
				r_c[i] = 23'(RClamp);
			end else if (df[i] < -28'(RClamp)) begin
				r_c[i] = -23'(RClamp);
			end else begin
				r_c[i] = df[i][22:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s1[i]  <= pt[i] - c16[i];
			d_s2[i]  <= d_s1[i];
			hp_s2[i] <= d_s1[i] * a_c[i];
			d_s3[i]  <= d_s2[i];
			d_s4[i]  <= d_s3[i];
			kp_s4[i] <= hq_s3 * a_c[i];
			r_s5[i]  <= r_c[i];
			tc_s5[i] <= c16[i] + k_c[i];
			tc_s6[i] <= tc_s5[i];
			us_s6[i] <= r_s5[i] * s_c[i];
			vw_s6[i] <= r_s5[i] * w_q[i];
			rr_s6[i] <= r_s5[i] * r_s5[i];
			nr_s6[i] <= r_s5[i] * $signed({1'b0, cyl_radius_q});
		end
		hq_s3  <= hfr[38:14];
		hq_s4  <= hq_s3;
		hq_s5  <= hq_s4;
		hq_s6  <= hq_s5;
		hit_s6 <= (r_s5[0] == '0) && (r_s5[1] == '0) && (r_s5[2] == '0);
	end

	// stage 7 sums feed the square root, the divider and the angle
	logic signed [40:0] u_s7;
	logic signed [43:0] v_s7;
	logic [45:0] sq_c;
	logic [41:0] nabs [3];

	logic [61:0]        rt_rem_s  [0:SqN];
	logic [30:0]        rt_root_s [0:SqN];
	logic [2:0][49:0]   rt_an_s   [0:SqN];
	tail_t              tail_s    [0:SqN];
	logic               rt_vld_s  [0:SqN];

	always_comb begin
		sq_c = rr_s6[0][45:0] + rr_s6[1][45:0] + rr_s6[2][45:0];
		for (int i = 0; i < 3; i++) begin
			nabs[i] = nr_s6[i] < 0 ? 42'(-nr_s6[i]) : 42'(nr_s6[i]);
		end
	end

	always_ff @(posedge clk) begin
		u_s7         <= us_s6[0] + us_s6[1] + us_s6[2];
		v_s7         <= vw_s6[0] + vw_s6[1] + vw_s6[2];
		rt_rem_s[0]  <= {sq_c, 16'b0};
		rt_root_s[0] <= '0;
		for (int i = 0; i < 3; i++) begin
			rt_an_s[0][i]   <= {nabs[i], 8'b0};
			tail_s[0].tc[i] <= tc_s6[i];
			tail_s[0].neg[i] <= nr_s6[i] < 0;
		end
		tail_s[0].hit <= hit_s6;
		tail_s[0].hq  <= hq_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_vld_s[0] <= 1'b0;
		end else begin
			rt_vld_s[0] <= v_s6;
		end
	end

	// bitwise square root, one result bit per stage
	for (genvar gj = 0; gj < SqN; gj++) begin : g_sqrt
		localparam int B = SqN - 1 - gj;
		logic [62:0] trial;
		assign trial = (63'(rt_root_s[gj]) << (B + 1)) | (63'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if ({1'b0, rt_rem_s[gj]} >= trial) begin
				rt_rem_s[gj+1]  <= rt_rem_s[gj] - trial[61:0];
				rt_root_s[gj+1] <= rt_root_s[gj] | (31'(1) << B);
			end else begin
				rt_rem_s[gj+1]  <= rt_rem_s[gj];
				rt_root_s[gj+1] <= rt_root_s[gj];
			end
			rt_an_s[gj+1] <= rt_an_s[gj];
			tail_s[gj+1]  <= tail_s[gj];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[gj+1] <= 1'b0;
			end else begin
				rt_vld_s[gj+1] <= rt_vld_s[gj];
			end
		end
	end

	// restoring divider, rounded offset magnitude per lane
	logic [2:0][49:0] dv_rem_s  [0:DivN];
	logic [2:0][19:0] dv_q_s    [0:DivN];
	logic [30:0]      dv_mag_s  [0:DivN];
	tail_t            dv_tail_s [0:DivN];
	logic             dv_vld_s  [0:DivN];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= rt_an_s[SqN][i] + 50'(rt_root_s[SqN] >> 1);
		end
		dv_q_s[0]    <= '0;
		dv_mag_s[0]  <= rt_root_s[SqN];
		dv_tail_s[0] <= tail_s[SqN];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= rt_vld_s[SqN];
		end
	end

	for (genvar gj = 0; gj < DivN; gj++) begin : g_div
		localparam int B = DivN - 1 - gj;
		logic [50:0] dsh;
		assign dsh = 51'(dv_mag_s[gj]) << B;

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if ({1'b0, dv_rem_s[gj][i]} >= dsh) begin
					dv_rem_s[gj+1][i] <= dv_rem_s[gj][i] - dsh[49:0];
					dv_q_s[gj+1][i]   <= dv_q_s[gj][i] | (20'(1) << B);
				end else begin
					dv_rem_s[gj+1][i] <= dv_rem_s[gj][i];
					dv_q_s[gj+1][i]   <= dv_q_s[gj][i];
				end
			end
			dv_mag_s[gj+1]  <= dv_mag_s[gj];
			dv_tail_s[gj+1] <= dv_tail_s[gj];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[gj+1] <= 1'b0;
			end else begin
				dv_vld_s[gj+1] <= dv_vld_s[gj];
			end
		end
	end

	// vectoring cordic for the angle as a fraction of a turn
	logic signed [47:0] cor_u_s    [0:CORDIC_STEPS];
	logic signed [47:0] cor_v_s    [0:CORDIC_STEPS];
	logic signed [25:0] cor_z_s    [0:CORDIC_STEPS];
	logic               cor_zero_s [0:CORDIC_STEPS];

	always_ff @(posedge clk) begin
		cor_zero_s[0] <= (u_s7 == '0) && (v_s7 == '0);
		if (u_s7 < 0) begin
			cor_u_s[0] <= -48'(u_s7);
			cor_v_s[0] <= -48'(v_s7);
			cor_z_s[0] <= 26'sd1 <<< (TurnBits - 1);
		end else begin
			cor_u_s[0] <= 48'(u_s7);
			cor_v_s[0] <= 48'(v_s7);
			cor_z_s[0] <= '0;
		end
	end

	for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
		localparam logic signed [25:0] At = $signed({4'b0000, AtanTurn[gi]});

		always_ff @(posedge clk) begin
			if (cor_v_s[gi] > 0) begin
				cor_u_s[gi+1] <= cor_u_s[gi] + (cor_v_s[gi] >>> gi);
				cor_v_s[gi+1] <= cor_v_s[gi] - (cor_u_s[gi] >>> gi);
				cor_z_s[gi+1] <= cor_z_s[gi] + At;
			end else begin
				cor_u_s[gi+1] <= cor_u_s[gi] - (cor_v_s[gi] >>> gi);
				cor_v_s[gi+1] <= cor_v_s[gi] + (cor_u_s[gi] >>> gi);
				cor_z_s[gi+1] <= cor_z_s[gi] - At;
			end
			cor_zero_s[gi+1] <= cor_zero_s[gi];
		end
	end

	// arc = circumference * turn, split multiply then round and clamp
	logic [TurnBits-1:0] turn_c;
	logic [41:0] prod_lo_sm, prod_hi_sm;
	logic [60:0] arc_sum;
	logic [ArcW:0] arc_raw;
	logic [ArcW-1:0] arc_d_s [0:ArcDly];

	assign turn_c = cor_zero_s[CORDIC_STEPS] ? '0 : cor_z_s[CORDIC_STEPS][TurnBits-1:0];

	always_comb begin
		arc_sum = {prod_hi_sm, 18'b0} + 61'(prod_lo_sm) + (61'(1) << 37);
		arc_raw = arc_sum[60:38];
	end

	always_ff @(posedge clk) begin
		prod_lo_sm <= circ_q[17:0] * turn_c;
		prod_hi_sm <= circ_q[35:18] * turn_c;
		arc_d_s[0] <= (arc_raw > ArcMax) ? ArcMax[ArcW-1:0] : arc_raw[ArcW-1:0];
		for (int j = 0; j < ArcDly; j++) begin
			arc_d_s[j+1] <= arc_d_s[j];
		end
	end

	// output stage
	tail_t tl;
	logic signed [20:0] off_c  [3];
	logic signed [28:0] sum_c  [3];
	logic signed [CoordW-1:0] surf_c [3];
	logic signed [CoordW-1:0] surf_q [3];

	assign tl = dv_tail_s[DivN];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_c[i] = tl.neg[i] ? -$signed({1'b0, dv_q_s[DivN][i]})
			                     :  $signed({1'b0, dv_q_s[DivN][i]});
			sum_c[i] = $signed(tl.tc[i]) + off_c[i];
			surf_c[i] = tl.hit ? sat_coord(29'($signed(tl.tc[i]))) : sat_coord(sum_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			surf_q[i] <= surf_c[i];
		end
		arc_pos <= tl.hit ? '0 : arc_d_s[ArcDly];
		height  <= sat_coord(29'(tl.hq));
		on_axis <= tl.hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld_s[DivN];
		end
	end

	assign surf_x = surf_q[0];
	assign surf_y = surf_q[1];
	assign surf_z = surf_q[2];

endmodule

`default_nettype wire

[design/cup_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module cup_props (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         done,
	input wire logic                         on_axis,
	input wire logic [cup_pkg::ArcW-1:0]     arc_pos
);
	import cup_pkg::*;

	`CUP_ASSERT_DELAY(a_item_gives_result, clk, arst_n, start && !busy, Latency, done)
	`CUP_ASSERT_IMPL(a_result_has_item, clk, arst_n, done, $past(start && !busy, Latency))
	`CUP_ASSERT_IMPL(a_axis_arc_zero, clk, arst_n, done && on_axis, arc_pos == '0)
	`CUP_ASSERT_IMPL(a_never_busy, clk, arst_n, $past(start), !busy)

endmodule

bind cylinder_unwrap_projector cup_props u_cup_props (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.on_axis (on_axis),
	.arc_pos (arc_pos)
);

`default_nettype wire

[verif/cup_checker.sv]
`default_nettype none

module cup_checker
	import cup_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     busy,
	input  wire logic signed [CoordW-1:0] point_x,
	input  wire logic signed [CoordW-1:0] point_y,
	input  wire logic signed [CoordW-1:0] point_z,
	input  wire logic                     cfg_we,
	input  wire logic [CfgIdxW-1:0]       cfg_idx,
	input  wire logic [VecW-1:0]          cfg_wdata,
	input  wire logic                     done,
	input  wire logic signed [CoordW-1:0] surf_x,
	input  wire logic signed [CoordW-1:0] surf_y,
	input  wire logic signed [CoordW-1:0] surf_z,
	input  wire logic [ArcW-1:0]          arc_pos,
	input  wire logic signed [CoordW-1:0] height,
	input  wire logic                     on_axis,
	output int                            fails,
	output int                            pending
);

	typedef struct packed {
		logic signed [CoordW-1:0] sx;
		logic signed [CoordW-1:0] sy;
		logic signed [CoordW-1:0] sz;
		logic [ArcW-1:0]          arc;
		logic signed [CoordW-1:0] hgt;
		logic                     axis_hit;
	} projection_t;

	logic [VecW-1:0] ax_point, ax_dir, rf_dir;
	logic [RadW-1:0] radius;
	projection_t expected_q[$];

	function automatic longint lane(logic [VecW-1:0] v, int k);
		logic signed [15:0] c;
		c = v[16*k +: 16];
		return longint'(c);
	endfunction

	function automatic longint round_shift(longint x, int n);
		return (x + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clip(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned turn_of(longint u, longint v);
		longint ang, du, dv;
		ang = 0;
		if (u == 0 && v == 0) return 0;
		if (u < 0) begin
			u = -u;
			v = -v;
			ang = longint'(1) <<< (TurnBits - 1);
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			du = v >>> i;
			dv = u >>> i;
			if (v > 0) begin
				u += du; v -= dv; ang += longint'(AtanTurn[i]);
			end else begin
				u -= du; v += dv; ang -= longint'(AtanTurn[i]);
			end
		end
		return longint'(ang) & ((longint'(1) << TurnBits) - 1);
	endfunction

	function automatic projection_t project(longint p[3]);
		projection_t o;
		longint c[3], a[3], s[3], w[3], d[3], k[3], r[3], tc[3];
		longint hf, hq, u, v, rad, mag, circ, num, an, q, off;
		longint unsigned sq, arc, trn;
		hf = 0; u = 0; v = 0; sq = 0; arc = 0;
		rad = longint'(radius);
		for (int i = 0; i < 3; i++) begin
			c[i] = lane(ax_point, i) * 16;
			a[i] = lane(ax_dir, i);
			s[i] = lane(rf_dir, i);
			d[i] = p[i] - c[i];
			hf += d[i] * a[i];
		end
		hq = round_shift(hf, 14);
		for (int i = 0; i < 3; i++) begin
			k[i] = round_shift(hq * a[i], 14);
			tc[i] = c[i] + k[i];
			r[i] = clip(d[i] - k[i], -RClamp, RClamp);
		end
		o.axis_hit = (r[0] == 0 && r[1] == 0 && r[2] == 0);
		w[0] = round_shift(s[1] * a[2] - s[2] * a[1], 14);
		w[1] = round_shift(s[2] * a[0] - s[0] * a[2], 14);
		w[2] = round_shift(s[0] * a[1] - s[1] * a[0], 14);
		for (int i = 0; i < 3; i++) begin
			u += r[i] * s[i];
			v += r[i] * w[i];
			sq += longint'(r[i] * r[i]);
		end
		if (o.axis_hit) begin
			o.sx = CoordW'(clip(tc[0], -524288, 524287));
			o.sy = CoordW'(clip(tc[1], -524288, 524287));
			o.sz = CoordW'(clip(tc[2], -524288, 524287));
		end else begin
			mag = longint'(int_sqrt(sq << 16));
			circ = round_shift(rad * longint'(TwoPiQ28), 14);
			trn = turn_of(u, v);
			for (int i = 0; i < 3; i++) begin
				num = r[i] * rad * 256;
				an = num < 0 ? -num : num;
				q = (an + mag / 2) / mag;
				off = num < 0 ? -q : q;
				tc[i] = clip(tc[i] + off, -524288, 524287);
			end
			o.sx = CoordW'(tc[0]);
			o.sy = CoordW'(tc[1]);
			o.sz = CoordW'(tc[2]);
			arc = (longint'(circ) * trn + (64'd1 << 37)) >> 38;
			if (arc > 4194303) arc = 4194303;
		end
		o.arc = arc[ArcW-1:0];
		o.hgt = CoordW'(clip(hq, -524288, 524287));
		return o;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint pt[3];
		projection_t e;
		if (!arst_n) begin
			ax_point <= '0;
			ax_dir <= AxisDirRst;
			rf_dir <= RefDirRst;
			radius <= RadRst;
			expected_q.delete();
		end else begin
			if (start && !busy) begin
				pt[0] = point_x;
				pt[1] = point_y;
				pt[2] = point_z;
				expected_q = {expected_q, project(pt)};
			end
			if (done) begin
				if (expected_q.size() == 0) begin
					report("done", 1, 0);
				end else begin
					e = expected_q.pop_front();
					if (surf_x !== e.sx) report("surf_x", surf_x, e.sx);
					if (surf_y !== e.sy) report("surf_y", surf_y, e.sy);
					if (surf_z !== e.sz) report("surf_z", surf_z, e.sz);
					if (arc_pos !== e.arc) report("arc_pos", arc_pos, e.arc);
					if (height !== e.hgt) report("height", height, e.hgt);
					if (on_axis !== e.axis_hit) report("on_axis", on_axis, e.axis_hit);
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_AXIS_POINT: ax_point <= cfg_wdata;
					REG_AXIS_DIR:   ax_dir <= cfg_wdata;
					REG_REF_DIR:    rf_dir <= cfg_wdata;
					REG_CYL_RADIUS: radius <= cfg_wdata[RadW-1:0];
					default: ;
				endcase
			end
		end
		pending = expected_q.size();
	end

	initial begin
		fails = 0;
		pending = 0;
	end

endmodule

`default_nettype wire

[verif/tb_cylinder_unwrap_projector.sv]
`default_nettype none

module tb_cylinder_unwrap_projector;
	import cup_pkg::*;

	localparam int WatchLimit = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CoordW-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = '0;
	logic [VecW-1:0] cfg_wdata = '0;
	logic done, on_axis;
	logic signed [CoordW-1:0] surf_x, surf_y, surf_z, height;
	logic [ArcW-1:0] arc_pos;
	int fails, pending;
	int idle_pct = 0;
	int quiet_cycles = 0;
	longint ctr[3];
	int axis_k = 1;

	cylinder_unwrap_projector dut (.*);
	cup_checker chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send(longint x, longint y, longint z);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		point_x <= x[CoordW-1:0];
		point_y <= y[CoordW-1:0];
		point_z <= z[CoordW-1:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (Latency + 4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [VecW-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [VecW-1:0] unit_vec(int k, bit neg);
		logic [VecW-1:0] v;
		v = '0;
		v[16*k +: 16] = neg ? 16'hC000 : 16'h4000;
		return v;
	endfunction

	task automatic set_cylinder(logic [VecW-1:0] ap, logic [VecW-1:0] ad,
			logic [VecW-1:0] rd, logic [RadW-1:0] rad, int k);
		logic signed [15:0] c;
		drain();
		write_reg(REG_AXIS_POINT, ap);
		write_reg(REG_AXIS_DIR, ad);
		write_reg(REG_REF_DIR, rd);
		write_reg(REG_CYL_RADIUS, {29'd0, rad});
		for (int i = 0; i < 3; i++) begin
			c = ap[16*i +: 16];
			ctr[i] = longint'(c) * 16;
		end
		axis_k = k;
	endtask

	task automatic random_cylinder();
		int k, sel;
		logic [VecW-1:0] ap;
		sel = $urandom_range(3);
		k = $urandom_range(2);
		ap = VecW'({$urandom, $urandom});
		if (sel == 0) begin
			set_cylinder(ap, VecW'({$urandom, $urandom}), VecW'({$urandom, $urandom}),
				RadW'($urandom), -1);
		end else if (sel == 1) begin
			set_cylinder({16'h7fff, 16'h8000, 16'h7fff}, unit_vec(k, $urandom_range(1)),
				unit_vec((k + 1) % 3, $urandom_range(1)), 19'h7ffff, k);
		end else begin
			set_cylinder(ap, unit_vec(k, $urandom_range(1)),
				unit_vec((k + 2) % 3, $urandom_range(1)), RadW'($urandom_range(102400)), k);
		end
	endtask

	task automatic random_point();
		longint p[3];
		longint t;
		int mode;
		mode = $urandom_range(9);
		t = longint'($urandom_range(200000)) - 100000;
		for (int i = 0; i < 3; i++) begin
			if (mode < 4) p[i] = longint'($signed($urandom_range(1048575) - 524288));
			else if (mode < 8) p[i] = ctr[i] + longint'($urandom_range(131072)) - 65536;
			else p[i] = ctr[i];
		end
		if (mode >= 8 && axis_k >= 0) p[axis_k] += t;
		send(p[0], p[1], p[2]);
	endtask

	initial begin
		ctr = '{0, 0, 0};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(0, 0, 0);
		send(0, 524287, 0);
		send(0, -524288, 0);
		send(524287, 524287, 524287);
		send(-524288, -524288, -524288);
		send(524287, -524288, 0);
		send(40960, 0, 0);
		send(0, 0, -1000);
		send(-40960, 12345, 1);
		send(3, -7, -40960);
		set_cylinder('0, unit_vec(2, 0), unit_vec(2, 0), 19'd1024, 2);
		send(5000, 100, 200);
		send(-524288, 524287, 0);
		send(0, 0, 300);
		set_cylinder({16'h8000, 16'h7fff, 16'h8000}, {3{16'h8000}}, {3{16'h7fff}},
			19'h7ffff, -1);
		send(524287, 524287, 524287);
		send(-524288, -524288, -524288);
		send(524287, -524288, 524287);
		send(0, 0, 0);
		set_cylinder({16'hffff, 16'h0010, 16'h0000}, unit_vec(0, 1), unit_vec(1, 0),
			19'd0, 0);
		send(1000, 2000, 3000);
		send(-16, 256, 0);
		send(0, -524288, 524287);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 32 : ((ph == 1) ? 46 : 0);
			for (int c = 0; c < 4; c++) begin
				random_cylinder();
				for (int n = 0; n < 57; n++) begin
					random_point();
					if (ph == 0 && c == 1 && n == 20) drain();
				end
			end
		end

		drain();
		if (fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
